### src/shfm_pkg.sv
// Shared constants, types, tables and arithmetic helpers for the stereo FFT magnitude core.
package shfm_pkg;

  // Transform size and derived widths
  localparam int POINTS   = 1024;
  localparam int LOG2N    = $clog2(POINTS);
  localparam int HALF     = POINTS / 2;
  localparam int QUART    = POINTS / 4;
  localparam int POS_W    = LOG2N;
  localparam int BANK_AW  = LOG2N + 1;
  localparam int HALF_AW  = LOG2N - 1;
  localparam int STG_W    = $clog2(LOG2N);

  // Datapath widths
  localparam int SMP_W    = 16;
  localparam int DW       = 39;
  localparam int TW_W     = 26;
  localparam int WIN_W    = 32;
  localparam int MAG_W    = 22;
  localparam int BIN_W    = 9;
  localparam int CMP_W    = 28;
  localparam int SQ_W     = 56;
  localparam int ROOT_STEPS = SQ_W / 4;
  localparam int ROOT_CW  = $clog2(ROOT_STEPS);

  // Magnitude scaling
  localparam int MAG_SHIFT = 4 + LOG2N / 2;
  localparam int SQ_SHIFT  = 8 + (LOG2N % 2);
  localparam logic [MAG_W-1:0] MAG_MAX  = {MAG_W{1'b1}};
  localparam logic [DW:0]      COMP_MAX = (DW + 1)'(1) << 27;

  // Trig constants
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam int Q_WIN = POINTS - 1;
  localparam int Q_TW  = POINTS;

  typedef enum logic [3:0] {
    E_IDLE, E_LOAD, E_BF_RA, E_BF_RB, E_BF_MUL, E_BF_SUM, E_BF_WA, E_BF_WB,
    E_MG_RD, E_MG_WAIT, E_MG_RUN
  } eng_state_e;

  typedef enum logic [2:0] {M_IDLE, M_SQ, M_SUM, M_ROOT, M_DONE} mag_state_e;

  // One work entry: both channels, complex
  typedef struct packed {
    logic signed [DW-1:0] lre;
    logic signed [DW-1:0] lim;
    logic signed [DW-1:0] rre;
    logic signed [DW-1:0] rim;
  } work_t;

  // Spectrum store write request
  typedef struct packed {
    logic               we;
    logic [HALF_AW-1:0] addr;
    logic [2*MAG_W-1:0] data;
  } spec_wr_t;

  typedef struct packed {
    logic signed [63:0] c;
    logic signed [63:0] s;
  } trig_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] res;
    logic [SQ_W-1:0] bt;
  } sq_t;

  typedef logic [WIN_W-1:0] win_tab_t [HALF];
  typedef logic [TW_W-2:0]  tw_tab_t  [QUART+1];

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (Q30_ONE >> 1)) >> 30;
  endfunction

  // Round half away from zero, then shift right by n
  function automatic logic signed [65:0] rshift_round(input logic signed [65:0] v, input int n);
    logic [65:0] m;
    logic [65:0] r;
    m = v[65] ? 66'(-v) : 66'(v);
    r = (m + (66'd1 << (n - 1))) >> n;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  // cos and sin of 2*pi*p/q in Q30, q is the window or the twiddle period
  function automatic trig_t trig_turn(input logic [63:0] p, input logic win);
    logic [63:0] q, full, a, x, x2, t, cv, sv, tmp;
    logic        sneg, cneg, swap;
    trig_t       r;
    q    = win ? 64'(Q_WIN) : 64'(Q_TW);
    full = q << 2;
    a    = (p >= q) ? (p - q) << 2 : p << 2;
    sneg = 1'b0;
    cneg = 1'b0;
    swap = 1'b0;
    if ((a << 1) > full) begin
      a = full - a;
      sneg = 1'b1;
    end
    if ((a << 2) > full) begin
      a = (full >> 1) - a;
      cneg = 1'b1;
    end
    if ((a << 3) > full) begin
      a = (full >> 2) - a;
      swap = 1'b1;
    end
    x  = win ? (PI_Q30 * a + 64'(Q_WIN)) / 64'(2 * Q_WIN)
             : (PI_Q30 * a + 64'(Q_TW)) / 64'(2 * Q_TW);
    x2 = mul_q30(x, x);
    t  = Q30_ONE;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd90;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd56;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd30;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd12;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd2;
    cv = t;
    t  = Q30_ONE;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd110;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd72;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd42;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd20;
    t  = Q30_ONE - mul_q30(x2, t) / 64'd6;
    sv = mul_q30(x, t);
    if (swap) begin
      tmp = cv;
      cv  = sv;
      sv  = tmp;
    end
    r.c = cneg ? -$signed(cv) : $signed(cv);
    r.s = sneg ? -$signed(sv) : $signed(sv);
    return r;
  endfunction

  // Twice the Hann weight in Q30, first half (the window is symmetric)
  function automatic win_tab_t build_win();
    win_tab_t w;
    trig_t    tr;
    for (int i = 0; i < HALF; i++) begin
      tr   = trig_turn(64'(i), 1'b1);
      w[i] = WIN_W'(Q30_ONE - 64'(tr.c));
    end
    return w;
  endfunction

  function automatic tw_tab_t build_tw(input logic want_sin);
    tw_tab_t w;
    trig_t   tr;
    for (int k = 0; k <= QUART; k++) begin
      tr   = trig_turn(64'(k), 1'b0);
      w[k] = (TW_W - 1)'(rshift_round(66'(want_sin ? tr.s : tr.c), 6));
    end
    return w;
  endfunction

  localparam win_tab_t WIN2_TAB = build_win();
  localparam tw_tab_t  TW_COS   = build_tw(1'b0);
  localparam tw_tab_t  TW_SIN   = build_tw(1'b1);

  function automatic logic [LOG2N-1:0] bitrev(input logic [LOG2N-1:0] v);
    logic [LOG2N-1:0] r;
    for (int b = 0; b < LOG2N; b++) r[b] = v[LOG2N-1-b];
    return r;
  endfunction

  // One step of the digit-by-digit integer square root
  function automatic sq_t sq_step(input sq_t s);
    sq_t n;
    n = s;
    if (s.v >= s.res + s.bt) begin
      n.v   = s.v - (s.res + s.bt);
      n.res = (s.res >> 1) + s.bt;
    end else begin
      n.res = s.res >> 1;
    end
    n.bt = s.bt >> 2;
    return n;
  endfunction

endpackage

### src/shfm_ram.sv
// Generic simple dual-port RAM with registered read.
module shfm_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/shfm_mag.sv
// One-lane magnitude unit: rounding, saturation, squares and iterative square root.
module shfm_mag (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [shfm_pkg::DW-1:0] re_i,
  input  logic signed [shfm_pkg::DW-1:0] im_i,
  output logic                          done_o,
  output logic [shfm_pkg::MAG_W-1:0]    mag_o
);
  import shfm_pkg::*;

  mag_state_e        state_q, state_d;
  logic [ROOT_CW-1:0] cnt_q;
  logic [CMP_W-1:0]  r_q, i_q;
  logic              sat_q;
  logic [SQ_W-1:0]   rsq_q, isq_q;
  sq_t               sq_q, sq_one, sq_two;
  logic [DW-1:0]     mre, mim;
  logic [DW:0]       r_full, i_full;

  // Round the component magnitudes
  always_comb begin
    mre    = re_i[DW-1] ? DW'(-re_i) : DW'(re_i);
    mim    = im_i[DW-1] ? DW'(-im_i) : DW'(im_i);
    r_full = ({1'b0, mre} + ((DW + 1)'(1) << (MAG_SHIFT - 1))) >> MAG_SHIFT;
    i_full = ({1'b0, mim} + ((DW + 1)'(1) << (MAG_SHIFT - 1))) >> MAG_SHIFT;
    sq_one = sq_step(sq_q);
    sq_two = sq_step(sq_one);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      M_IDLE:  if (start_i) state_d = M_SQ;
      M_SQ:    state_d = M_SUM;
      M_SUM:   state_d = M_ROOT;
      M_ROOT:  if (cnt_q == ROOT_CW'(ROOT_STEPS - 1)) state_d = M_DONE;
      M_DONE:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done_o = 1'b0;
    mag_o  = MAG_MAX;
    case (state_q)
      M_DONE: begin
        done_o = 1'b1;
        if (!sat_q && sq_q.res <= SQ_W'(MAG_MAX)) mag_o = MAG_W'(sq_q.res);
      end
      default: done_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == M_ROOT) cnt_q <= cnt_q + 1'b1;
      else cnt_q <= '0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        r_q   <= CMP_W'(r_full);
        i_q   <= CMP_W'(i_full);
        sat_q <= (r_full > COMP_MAX) || (i_full > COMP_MAX);
      end
      M_SQ: begin
        rsq_q <= SQ_W'(r_q) * SQ_W'(r_q);
        isq_q <= SQ_W'(i_q) * SQ_W'(i_q);
      end
      M_SUM: begin
        sq_q.v   <= (rsq_q + isq_q) >> SQ_SHIFT;
        sq_q.res <= '0;
        sq_q.bt  <= SQ_W'(1) << (SQ_W - 2);
      end
      M_ROOT:  sq_q <= sq_two;
      default: sq_q <= sq_q;
    endcase
  end

endmodule

### src/shfm_engine.sv
// Transform sequencer: windowed load, in-place radix-2 butterflies and magnitude pass.
module shfm_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic                          bank_i,
  output logic                          busy_o,
  output logic [shfm_pkg::BANK_AW-1:0]  bank_raddr_o,
  input  logic [2*shfm_pkg::SMP_W-1:0]  bank_rdata_i,
  output shfm_pkg::spec_wr_t            spec_wr_o
);
  import shfm_pkg::*;

  eng_state_e state_q, state_d;

  // Work memory
  logic             w_we;
  logic [LOG2N-1:0] w_waddr, w_raddr;
  work_t            w_wdata, w_rdata;

  shfm_ram #(.Width($bits(work_t)), .Depth(POINTS)) u_work_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(w_wdata),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  // Load pipeline
  logic                    bank_q;
  logic [LOG2N:0]          ld_cnt_q;
  logic                    ld_issue, ld_v1_q, ld_v2_q;
  logic [LOG2N-1:0]        ld_i1_q, ld_i2_q;
  logic [HALF_AW-1:0]      widx;
  logic [WIN_W-1:0]        win_q;
  logic signed [SMP_W-1:0] smp_l, smp_r;
  logic signed [SMP_W+WIN_W:0] pl_q, pr_q;
  work_t                   ld_word;

  // Butterfly
  logic [STG_W-1:0]        stg_q;
  logic [HALF_AW-1:0]      bf_q, lo_mask, j_part, hi_part, tw_k, tw_kf;
  logic [LOG2N-1:0]        ia_c, ib_c, ia_q, ib_q;
  logic signed [TW_W-1:0]  wr_q, wi_q;
  work_t                   a_q, sum_a, dif_b;
  logic signed [DW+TW_W-1:0] p_lrr_q, p_lii_q, p_lri_q, p_lir_q;
  logic signed [DW+TW_W-1:0] p_rrr_q, p_rii_q, p_rri_q, p_rir_q;
  logic signed [DW-1:0]    tl_re_q, tl_im_q, tr_re_q, tr_im_q;
  logic                    bf_last;

  // Magnitude pass
  logic [HALF_AW-1:0]      mk_q;
  logic                    mag_start, mag_done_l, mag_done_r;
  logic [MAG_W-1:0]        mag_l, mag_r;

  shfm_mag u_mag_l (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mag_start),
    .re_i   (w_rdata.lre),
    .im_i   (w_rdata.lim),
    .done_o (mag_done_l),
    .mag_o  (mag_l)
  );

  shfm_mag u_mag_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mag_start),
    .re_i   (w_rdata.rre),
    .im_i   (w_rdata.rim),
    .done_o (mag_done_r),
    .mag_o  (mag_r)
  );

  assign busy_o = (state_q != E_IDLE);

  // Butterfly addressing and twiddle folding
  always_comb begin
    lo_mask = HALF_AW'((1 << stg_q) - 1);
    j_part  = bf_q & lo_mask;
    hi_part = bf_q & ~lo_mask;
    ia_c    = {hi_part, 1'b0} | {1'b0, j_part};
    ib_c    = ia_c | (LOG2N'(1) << stg_q);
    tw_k    = j_part << (STG_W'(LOG2N - 1) - stg_q);
    tw_kf   = tw_k[HALF_AW-1] ? HALF_AW'(-tw_k) : tw_k;
    bf_last = (stg_q == STG_W'(LOG2N - 1)) && (&bf_q);
    widx    = ld_cnt_q[LOG2N-1] ? ~ld_cnt_q[HALF_AW-1:0] : ld_cnt_q[HALF_AW-1:0];
  end

  // Windowed sample word and butterfly results
  always_comb begin
    smp_l       = bank_rdata_i[2*SMP_W-1:SMP_W];
    smp_r       = bank_rdata_i[SMP_W-1:0];
    ld_word.lre = DW'(rshift_round(66'(pl_q), 22));
    ld_word.lim = '0;
    ld_word.rre = DW'(rshift_round(66'(pr_q), 22));
    ld_word.rim = '0;
    sum_a.lre   = DW'(a_q.lre + tl_re_q);
    sum_a.lim   = DW'(a_q.lim + tl_im_q);
    sum_a.rre   = DW'(a_q.rre + tr_re_q);
    sum_a.rim   = DW'(a_q.rim + tr_im_q);
    dif_b.lre   = DW'(a_q.lre - tl_re_q);
    dif_b.lim   = DW'(a_q.lim - tl_im_q);
    dif_b.rre   = DW'(a_q.rre - tr_re_q);
    dif_b.rim   = DW'(a_q.rim - tr_im_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE:    if (go_i) state_d = E_LOAD;
      E_LOAD:    if (ld_v2_q && (&ld_i2_q)) state_d = E_BF_RA;
      E_BF_RA:   state_d = E_BF_RB;
      E_BF_RB:   state_d = E_BF_MUL;
      E_BF_MUL:  state_d = E_BF_SUM;
      E_BF_SUM:  state_d = E_BF_WA;
      E_BF_WA:   state_d = E_BF_WB;
      E_BF_WB:   state_d = bf_last ? E_MG_RD : E_BF_RA;
      E_MG_RD:   state_d = E_MG_WAIT;
      E_MG_WAIT: state_d = E_MG_RUN;
      E_MG_RUN:  if (mag_done_l) state_d = (&mk_q) ? E_IDLE : E_MG_RD;
      default:   state_d = E_IDLE;
    endcase
  end

  // Memory and unit controls
  always_comb begin
    bank_raddr_o = {bank_q, ld_cnt_q[LOG2N-1:0]};
    ld_issue     = 1'b0;
    w_raddr      = ia_q;
    w_we         = 1'b0;
    w_waddr      = ia_q;
    w_wdata      = sum_a;
    mag_start    = 1'b0;
    spec_wr_o    = '0;
    case (state_q)
      E_LOAD: begin
        ld_issue = !ld_cnt_q[LOG2N];
        w_we     = ld_v2_q;
        w_waddr  = bitrev(ld_i2_q);
        w_wdata  = ld_word;
      end
      E_BF_RA: w_raddr = ia_c;
      E_BF_RB: w_raddr = ib_q;
      E_BF_WA: w_we = 1'b1;
      E_BF_WB: begin
        w_we    = 1'b1;
        w_waddr = ib_q;
        w_wdata = dif_b;
      end
      E_MG_RD:   w_raddr = LOG2N'(mk_q);
      E_MG_WAIT: mag_start = 1'b1;
      E_MG_RUN: begin
        spec_wr_o.we   = mag_done_l && mag_done_r;
        spec_wr_o.addr = mk_q;
        spec_wr_o.data = {mag_l, mag_r};
      end
      default: w_we = 1'b0;
    endcase
  end

  // Control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= E_IDLE;
      ld_cnt_q <= '0;
      ld_v1_q  <= 1'b0;
      ld_v2_q  <= 1'b0;
      stg_q    <= '0;
      bf_q     <= '0;
      mk_q     <= '0;
    end else begin
      state_q <= state_d;
      ld_v1_q <= ld_issue;
      ld_v2_q <= ld_v1_q;
      if (state_q == E_IDLE) begin
        ld_cnt_q <= '0;
        stg_q    <= '0;
        bf_q     <= '0;
        mk_q     <= '0;
      end
      if (ld_issue) ld_cnt_q <= ld_cnt_q + 1'b1;
      if (state_q == E_BF_WB) begin
        bf_q <= bf_q + 1'b1;
        if (&bf_q) stg_q <= stg_q + 1'b1;
      end
      if (state_q == E_MG_RUN && mag_done_l) mk_q <= mk_q + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == E_IDLE && go_i) bank_q <= bank_i;
    win_q   <= WIN2_TAB[widx];
    ld_i1_q <= ld_cnt_q[LOG2N-1:0];
    ld_i2_q <= ld_i1_q;
    pl_q    <= smp_l * $signed({1'b0, win_q});
    pr_q    <= smp_r * $signed({1'b0, win_q});
    case (state_q)
      E_BF_RA: begin
        ia_q <= ia_c;
        ib_q <= ib_c;
        wr_q <= tw_k[HALF_AW-1] ? -$signed({1'b0, TW_COS[tw_kf]})
                                 :  $signed({1'b0, TW_COS[tw_kf]});
        wi_q <= -$signed({1'b0, TW_SIN[tw_kf]});
      end
      E_BF_RB: a_q <= w_rdata;
      E_BF_MUL: begin
        p_lrr_q <= w_rdata.lre * wr_q;
        p_lii_q <= w_rdata.lim * wi_q;
        p_lri_q <= w_rdata.lre * wi_q;
        p_lir_q <= w_rdata.lim * wr_q;
        p_rrr_q <= w_rdata.rre * wr_q;
        p_rii_q <= w_rdata.rim * wi_q;
        p_rri_q <= w_rdata.rre * wi_q;
        p_rir_q <= w_rdata.rim * wr_q;
      end
      E_BF_SUM: begin
        tl_re_q <= DW'(rshift_round(66'(p_lrr_q) - 66'(p_lii_q), 24));
        tl_im_q <= DW'(rshift_round(66'(p_lri_q) + 66'(p_lir_q), 24));
        tr_re_q <= DW'(rshift_round(66'(p_rrr_q) - 66'(p_rii_q), 24));
        tr_im_q <= DW'(rshift_round(66'(p_rri_q) + 66'(p_rir_q), 24));
      end
      default: a_q <= a_q;
    endcase
  end

endmodule

### src/stereo_hann_fft_magnitude_core.sv
// Top level of the stereo Hann-windowed FFT magnitude core.
//
// Request channel: a stereo frame (left_sample_i, right_sample_i) is taken at a rising
// edge with start high and busy low. Frames fill one of two sample banks in turn.
// Result channel: the k-th frame of a frame period (k below POINTS/2) returns bin k of
// the previous spectrum in the cycle after its request, for a single cycle with valid_o
// high; last_bin_o marks bin POINTS/2-1. No result before the first spectrum exists.
// Throughput: one frame per cycle, except that the last frame of a period starts the
// transform and holds busy until it is done (windowed load, one butterfly at a time
// on the work RAM, then one bin at a time through the square root unit).
// The receiver cannot stall: results are strobes and must be taken when shown.
// Reset clears the frame position, bank select and spectrum flag; memories are not
// cleared, as every entry is written before it is read.
module stereo_hann_fft_magnitude_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [shfm_pkg::SMP_W-1:0] left_sample_i,
  input  logic signed [shfm_pkg::SMP_W-1:0] right_sample_i,
  output logic                            valid_o,
  output logic [shfm_pkg::BIN_W-1:0]      bin_index_o,
  output logic [shfm_pkg::MAG_W-1:0]      left_magnitude_o,
  output logic [shfm_pkg::MAG_W-1:0]      right_magnitude_o,
  output logic                            last_bin_o
);
  import shfm_pkg::*;

  logic               accept, go;
  logic [POS_W-1:0]   pos_q;
  logic               bank_q, ready_q, valid_q;
  logic [HALF_AW-1:0] idx_q;
  logic [BANK_AW-1:0] bank_raddr;
  logic [2*SMP_W-1:0] bank_rdata;
  logic [2*MAG_W-1:0] spec_rdata;
  spec_wr_t           spec_wr;
  logic               eng_busy;

  assign accept = start && !busy;
  assign go     = accept && (&pos_q);
  assign busy   = eng_busy;

  // Sample banks, written by requests and read by the engine
  shfm_ram #(.Width(2 * SMP_W), .Depth(2 * POINTS)) u_bank_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i({bank_q, pos_q}),
    .wdata_i({left_sample_i, right_sample_i}),
    .raddr_i(bank_raddr),
    .rdata_o(bank_rdata)
  );

  // Spectrum store, written by the engine and read for results
  shfm_ram #(.Width(2 * MAG_W), .Depth(HALF)) u_spec_ram (
    .clk_i  (clk_i),
    .we_i   (spec_wr.we),
    .waddr_i(spec_wr.addr),
    .wdata_i(spec_wr.data),
    .raddr_i(pos_q[HALF_AW-1:0]),
    .rdata_o(spec_rdata)
  );

  shfm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .bank_i      (bank_q),
    .busy_o      (eng_busy),
    .bank_raddr_o(bank_raddr),
    .bank_rdata_i(bank_rdata),
    .spec_wr_o   (spec_wr)
  );

  // Advance frame position, swap banks at the end of a period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      bank_q  <= 1'b0;
      ready_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept && ready_q && !pos_q[LOG2N-1];
      if (accept) begin
        pos_q <= pos_q + 1'b1;
        if (&pos_q) begin
          bank_q  <= ~bank_q;
          ready_q <= 1'b1;
        end
      end
    end
  end

  // Hold the bin number of the pending result
  always_ff @(posedge clk_i) begin
    if (accept) idx_q <= pos_q[HALF_AW-1:0];
  end

  assign valid_o           = valid_q;
  assign bin_index_o       = BIN_W'(idx_q);
  assign left_magnitude_o  = spec_rdata[2*MAG_W-1:MAG_W];
  assign right_magnitude_o = spec_rdata[MAG_W-1:0];
  assign last_bin_o        = &idx_q;

endmodule

### src/shfm_checker.sv
// Port-level checks for the stereo FFT magnitude core, bound to the top level.
module shfm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic signed [shfm_pkg::SMP_W-1:0] left_sample_i,
  input logic signed [shfm_pkg::SMP_W-1:0] right_sample_i,
  input logic                            valid_o,
  input logic [shfm_pkg::BIN_W-1:0]      bin_index_o,
  input logic [shfm_pkg::MAG_W-1:0]      left_magnitude_o,
  input logic [shfm_pkg::MAG_W-1:0]      right_magnitude_o,
  input logic                            last_bin_o
);
  import shfm_pkg::*;

  // A result follows in the cycle after a request
  a_result_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy))
    else $error("result without a request one cycle before");

  // The request after the last bin falls in the second half and returns nothing
  a_no_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_bin_o) |=> !valid_o)
    else $error("result right after the last bin");

  // The transform starts only on a request
  a_busy_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without a request");

  // Drop no result into a transform period
  a_quiet_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !valid_o)
    else $error("result while busy");

endmodule

bind stereo_hann_fft_magnitude_core shfm_checker u_shfm_checker (.*);

### tb/tb_stereo_hann_fft_magnitude_core.sv
// Self-checking testbench for the stereo Hann-windowed FFT magnitude core.
`timescale 1ns / 1ps

module tb_stereo_hann_fft_magnitude_core;
  import shfm_pkg::*;

  localparam int NPT      = shfm_pkg::POINTS;
  localparam int NHALF    = NPT / 2;
  localparam int LG       = $clog2(NPT);
  localparam int AMP_SHR  = 4 + LG / 2;
  localparam int PWR_SHR  = 8 + (LG % 2);
  localparam int N_FRAMES = 1150;
  localparam int STALL_LIMIT = 200000;
  localparam logic [MAG_W-1:0] MAG_SAT = {MAG_W{1'b1}};

  typedef struct {
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] lmag;
    logic [MAG_W-1:0] rmag;
    logic             last;
  } bin_result_t;

  logic clk_i, rst_ni, start, busy, valid_o, last_bin_o;
  logic signed [SMP_W-1:0] left_sample_i, right_sample_i;
  logic [BIN_W-1:0] bin_index_o;
  logic [MAG_W-1:0] left_magnitude_o, right_magnitude_o;

  stereo_hann_fft_magnitude_core dut (.*);

  // Pending stereo frames and expected spectrum bins
  logic signed [SMP_W-1:0] left_q[$], right_q[$];
  bin_result_t             bin_q[$];

  // Predictor state
  logic [31:0]  frame_bank[2*NPT];
  logic [43:0]  mag_store[NHALF];
  int unsigned  fill_pos, fill_sel;
  bit           have_spectrum;
  longint       hann2[NPT];
  longint       twr[NHALF], twi[NHALF];
  longint       fre[NPT], fim[NPT];
  logic [MAG_W-1:0] left_mags[NHALF];

  int  errors, accepted, idle_pct, stall_cnt;
  bit  taken;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned mulq(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint rnd_shr(longint v, int n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (n - 1))) >> n;
    return (v < 0) ? -m : m;
  endfunction

  // cos/sin of 2*pi*p/q in Q30 via octant folding and Taylor series
  task automatic turn(input int unsigned p, input int unsigned q,
                      output longint c, output longint s);
    longint unsigned full, a, x, x2, t, cv, sv, tmp;
    longint unsigned cdiv[5] = '{90, 56, 30, 12, 2};
    longint unsigned sdiv[5] = '{110, 72, 42, 20, 6};
    bit sn, cn, sw;
    full = 4 * longint'(q);
    a    = 4 * longint'(p % q);
    sn = 0; cn = 0; sw = 0;
    if (2 * a > full) begin a = full - a; sn = 1; end
    if (4 * a > full) begin a = full / 2 - a; cn = 1; end
    if (8 * a > full) begin a = full / 4 - a; sw = 1; end
    x  = (64'd3373259426 * a + q) / (2 * longint'(q));
    x2 = mulq(x, x);
    t = 64'd1 << 30;
    for (int k = 0; k < 5; k++) t = (64'd1 << 30) - mulq(x2, t) / cdiv[k];
    cv = t;
    t = 64'd1 << 30;
    for (int k = 0; k < 5; k++) t = (64'd1 << 30) - mulq(x2, t) / sdiv[k];
    sv = mulq(x, t);
    if (sw) begin tmp = cv; cv = sv; sv = tmp; end
    c = cn ? -longint'(cv) : longint'(cv);
    s = sn ? -longint'(sv) : longint'(sv);
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [MAG_W-1:0] bin_mag(longint re, longint im);
    longint unsigned r, i, root;
    r = ((re < 0 ? -re : re) + (64'd1 << (AMP_SHR - 1))) >> AMP_SHR;
    i = ((im < 0 ? -im : im) + (64'd1 << (AMP_SHR - 1))) >> AMP_SHR;
    if (r > (64'd1 << 27) || i > (64'd1 << 27)) return MAG_SAT;
    root = int_sqrt((r * r + i * i) >> PWR_SHR);
    return (root > MAG_SAT) ? MAG_SAT : MAG_W'(root);
  endfunction

  function automatic int unsigned rev_bits(int unsigned v);
    int unsigned r;
    r = 0;
    for (int b = 0; b < LG; b++) r = (r << 1) | ((v >> b) & 1);
    return r;
  endfunction

  // Window and transform one channel of the given bank into fre/fim
  task automatic window_fft(input int unsigned sel, input bit left_lane);
    logic signed [15:0] smp;
    longint br, bi, tr, ti, ar, ai, wr, wi;
    int unsigned ia, ib, half;
    for (int i = 0; i < NPT; i++) begin
      smp = left_lane ? frame_bank[sel*NPT+i][31:16] : frame_bank[sel*NPT+i][15:0];
      fre[rev_bits(i)] = rnd_shr(longint'(smp) * hann2[i], 22);
      fim[rev_bits(i)] = 0;
    end
    for (int len = 2; len <= NPT; len <<= 1) begin
      half = len / 2;
      for (int base = 0; base < NPT; base += len)
        for (int j = 0; j < half; j++) begin
          ia = base + j;
          ib = ia + half;
          wr = twr[j * (NPT / len)];
          wi = twi[j * (NPT / len)];
          br = fre[ib]; bi = fim[ib];
          tr = rnd_shr(br * wr - bi * wi, 24);
          ti = rnd_shr(br * wi + bi * wr, 24);
          ar = fre[ia]; ai = fim[ia];
          fre[ia] = ar + tr; fim[ia] = ai + ti;
          fre[ib] = ar - tr; fim[ib] = ai - ti;
        end
    end
  endtask

  // Advance the predictor by one accepted stereo frame
  task automatic predict_frame(input logic [15:0] l, input logic [15:0] r);
    bin_result_t e;
    if (have_spectrum && fill_pos < NHALF) begin
      e.bin  = BIN_W'(fill_pos);
      e.lmag = mag_store[fill_pos][43:22];
      e.rmag = mag_store[fill_pos][21:0];
      e.last = (fill_pos == NHALF - 1);
      bin_q.push_back(e);
    end
    frame_bank[fill_sel*NPT + fill_pos] = {l, r};
    if (fill_pos == NPT - 1) begin
      window_fft(fill_sel, 1'b1);
      for (int i = 0; i < NHALF; i++) left_mags[i] = bin_mag(fre[i], fim[i]);
      window_fft(fill_sel, 1'b0);
      for (int i = 0; i < NHALF; i++) mag_store[i] = {left_mags[i], bin_mag(fre[i], fim[i])};
      fill_sel ^= 1;
      have_spectrum = 1;
      fill_pos = 0;
    end else fill_pos++;
  endtask

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Driver: present a request, hold it until taken, idle at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      taken <= 1'b0;
      if (left_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start          <= 1'b1;
        left_sample_i  <= left_q.pop_front();
        right_sample_i <= right_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results, then record accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o || (start && !busy)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (valid_o) begin
        if (bin_q.size() == 0) report("result with no request pending");
        else begin
          automatic bin_result_t e = bin_q.pop_front();
          if (bin_index_o !== e.bin)
            report($sformatf("bin %0d expected %0d", bin_index_o, e.bin));
          if (left_magnitude_o !== e.lmag)
            report($sformatf("bin %0d left %0d expected %0d", e.bin, left_magnitude_o, e.lmag));
          if (right_magnitude_o !== e.rmag)
            report($sformatf("bin %0d right %0d expected %0d", e.bin, right_magnitude_o,
                             e.rmag));
          if (last_bin_o !== e.last)
            report($sformatf("bin %0d last flag %0b", e.bin, last_bin_o));
        end
      end
      if (start && !busy) begin
        taken     <= 1'b1;
        accepted++;
        predict_frame(left_sample_i, right_sample_i);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL stereo_hann_fft_magnitude_core");
      $finish;
    end
  end

  // Stimulus, idling phases and end of run
  initial begin
    logic signed [SMP_W-1:0] lv, rv;
    logic signed [SMP_W-1:0] edge_vals[5];
    longint c, s;
    int style, period, amp;
    edge_vals = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
    rst_ni = 1'b0; start = 1'b0; taken = 1'b0;
    left_sample_i = '0; right_sample_i = '0;
    errors = 0; accepted = 0; stall_cnt = 0; idle_pct = 8;
    fill_pos = 0; fill_sel = 0; have_spectrum = 0;
    for (int i = 0; i < NPT; i++) begin
      turn(i, NPT - 1, c, s);
      hann2[i] = (64'sd1 <<< 30) - c;
    end
    for (int i = 0; i < NHALF; i++) begin
      turn(i, NPT, c, s);
      twr[i] = rnd_shr(c, 6);
      twi[i] = -rnd_shr(s, 6);
    end

    // Directed: every pairing of the sample extremes, zero and plus or minus one
    for (int a = 0; a < 5; a++)
      for (int b = 0; b < 5; b++) begin
        left_q.push_back(edge_vals[a]);
        right_q.push_back(edge_vals[b]);
      end
    // Random: blocks of noise, quiet noise, square tones (full-scale left, random amplitude right) and DC
    style = 0; period = 2; amp = 0;
    for (int n = left_q.size(); n < N_FRAMES; n++) begin
      if (n % 64 == 0) begin
        style  = $urandom_range(3);
        period = $urandom_range(64, 2);
        amp    = $urandom_range(32767);
      end
      case (style)
        0: begin
          lv = SMP_W'($urandom);
          rv = SMP_W'($urandom);
        end
        1: begin
          lv = SMP_W'($urandom_range(512) - 256);
          rv = SMP_W'($urandom_range(512) - 256);
        end
        2: begin
          lv = ((n / period) % 2) ? -16'sd32768 : 16'sd32767;
          rv = ((n / (period + 1)) % 2) ? SMP_W'(-amp) : SMP_W'(amp);
        end
        default: begin
          lv = SMP_W'(amp);
          rv = SMP_W'(-amp - 1);
        end
      endcase
      left_q.push_back(lv);
      right_q.push_back(rv);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    wait (accepted >= N_FRAMES / 3);
    idle_pct = 85;
    wait (accepted >= 2 * N_FRAMES / 3);
    idle_pct = 0;
    wait (accepted >= N_FRAMES && bin_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && bin_q.size() == 0) begin
      $display("PASS stereo_hann_fft_magnitude_core");
    end else begin
      $display("FAIL stereo_hann_fft_magnitude_core");
    end
    $finish;
  end

endmodule
